// ===== hdl/bsc_pkg.sv =====
// Shared types and constants for the byte scrambler with checksum.
// No dependencies; imported by every module of the block.
`default_nettype none

package bsc_pkg;

    localparam int KEY_LEN_MAX = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam int CNT_W = $clog2(KEY_LEN_MAX + 1);
    localparam int IDX_W = (KEY_LEN_MAX > 1) ? $clog2(KEY_LEN_MAX) : 1;

    localparam logic [1:0] MODE_SCRAMBLE   = 2'd0;
    localparam logic [1:0] MODE_UNSCRAMBLE = 2'd1;
    localparam logic [1:0] MODE_KEY        = 2'd2;

    localparam logic [7:0] LETTER_A     = 8'd97;
    localparam logic [7:0] ALPHA_LEN    = 8'd26;
    localparam logic [6:0] MOD26_RECIP  = 7'd79;
    localparam int         MOD26_SHIFT  = 11;

    typedef enum logic [1:0] {
        OP_SCRAMBLE,
        OP_UNSCRAMBLE,
        OP_KEY
    } op_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] check_sum;
        logic        last_result;
    } out_item_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic       eos;
    } q_item_t;

endpackage

`default_nettype wire

// ===== hdl/byte_scrambler_with_checksum.sv =====
// Top level of the byte scrambler with checksum: front end, item queue and
// back end. Depends on bsc_pkg, bsc_front, bsc_queue and bsc_back.
//
// Scramble and unscramble modes take one byte per cycle while results are
// taken and return one result per byte via a queue slot and the result
// register; that rate is set by the combinational chain update (byte add,
// 8x9 product and 16-bit add into the running sum). In key mode bytes are
// taken one per cycle with no result; a byte marked end of string starts the
// reverse walk over the n buffered bytes, one byte per cycle through the same
// multiplier, then a drain state to settle the last letter, then the n letters
// one per cycle while the result slot is free, as the two-item queue fills and
// input stalls. A waiting result stalls input only once the queue is full.
`default_nettype none

module byte_scrambler_with_checksum (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_mode,
    input  wire logic               byte_valid,
    output logic                    byte_ready,
    input  wire bsc_pkg::in_item_t  byte_item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output bsc_pkg::out_item_t      result_item
);
    import bsc_pkg::*;

    logic    q_full;
    logic    q_push;
    q_item_t q_push_item;
    logic    q_pop;
    logic    q_head_valid;
    q_item_t q_head_item;

    bsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_mode   (cfg_mode),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_push_item)
    );

    bsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    bsc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_head_valid),
        .head_item    (q_head_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule

`default_nettype wire

// ===== hdl/bsc_queue.sv =====
// Short item queue between the classifying front and the execution back end.
// Depends on bsc_pkg.
`default_nettype none

module bsc_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire bsc_pkg::q_item_t push_item,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output bsc_pkg::q_item_t      head_item
);
    import bsc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    q_item_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bsc_front.sv =====
// Front end: holds the mode register, accepts input items, tags each with its
// operation and queues it, or drops it in an unused mode. Depends on bsc_pkg.
`default_nettype none

module bsc_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_mode,
    input  wire logic              byte_valid,
    output logic                   byte_ready,
    input  wire bsc_pkg::in_item_t byte_item,
    input  wire logic              q_full,
    output logic                   q_push,
    output bsc_pkg::q_item_t       q_item
);
    import bsc_pkg::*;

    logic [1:0] mode_reg;
    logic       known_op;

    assign cfg_ready  = 1'b1;
    assign byte_ready = !q_full;

    always_comb
    begin
        q_item.data_byte = byte_item.data_byte;
        q_item.eos       = byte_item.end_of_string;
        known_op         = 1'b1;
        case (mode_reg)
            MODE_SCRAMBLE:   q_item.op = OP_SCRAMBLE;
            MODE_UNSCRAMBLE: q_item.op = OP_UNSCRAMBLE;
            MODE_KEY:        q_item.op = OP_KEY;
            default:
            begin
                // unused mode: item is taken and discarded
                q_item.op = OP_SCRAMBLE;
                known_op  = 1'b0;
            end
        endcase
    end

    assign q_push = byte_valid && byte_ready && known_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SCRAMBLE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= cfg_mode;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bsc_back.sv =====
// Back end: chain and checksum update, key buffer, reverse key walk and the
// registered result slot. Depends on bsc_pkg.
`default_nettype none

module bsc_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head_valid,
    input  wire bsc_pkg::q_item_t head_item,
    output logic                  q_pop,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output bsc_pkg::out_item_t    result_item
);
    import bsc_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_WALK,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    function automatic logic [7:0] key_letter(input logic [7:0] c);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [7:0]  r;
        // quotient by reciprocal multiply, exact for all byte values
        prod = c * MOD26_RECIP;
        q    = prod[MOD26_SHIFT+3:MOD26_SHIFT];
        r    = c - 8'(q * ALPHA_LEN);
        return LETTER_A + r;
    endfunction

    state_t              state_reg, state_next;
    logic [7:0]          prev_reg, prev_next;
    logic [15:0]         sum_reg, sum_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [15:0]         chk_reg, chk_next;
    logic [15:0]         walk_s_reg, walk_s_next;
    logic [7:0]          walk_p_reg, walk_p_next;
    logic [IDX_W-1:0]    walk_idx_reg, walk_idx_next;
    logic [IDX_W-1:0]    emit_idx_reg, emit_idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [7:0]          pend_c_reg, pend_c_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_item_reg, out_item_next;

    logic [7:0]          key_buf_reg [KEY_LEN_MAX];
    logic [7:0]          letter_reg [KEY_LEN_MAX];

    logic                out_free;
    logic [7:0]          scr_c, uns_r, walk_e, walk_c;
    logic [7:0]          mul_a;
    logic [8:0]          mul_b;
    logic [16:0]         prod;
    logic [15:0]         sum_base, sum_upd;
    logic                buf_we;
    logic                room;
    logic                emit_last;

    assign out_free  = !out_valid_reg || result_ready;
    assign scr_c     = head_item.data_byte + prev_reg - sum_reg[7:0];
    assign uns_r     = head_item.data_byte - prev_reg + sum_reg[7:0];
    assign walk_e    = key_buf_reg[walk_idx_reg];
    assign walk_c    = walk_e + walk_p_reg - walk_s_reg[7:0];
    assign room      = (fill_reg < CNT_W'(KEY_LEN_MAX));
    assign emit_last = (CNT_W'(emit_idx_reg) + CNT_W'(1) == n_reg);

    // one shared multiplier: walk update in the walk state, chain update otherwise
    always_comb
    begin
        if (state_reg == ST_WALK)
        begin
            mul_a    = walk_c;
            mul_b    = {1'b0, walk_p_reg} + 9'd1;
            sum_base = walk_s_reg;
        end
        else
        begin
            mul_a    = (head_item.op == OP_UNSCRAMBLE) ? head_item.data_byte : scr_c;
            mul_b    = {1'b0, mul_a} + 9'd1;
            sum_base = sum_reg;
        end
    end

    assign prod    = mul_a * mul_b;
    assign sum_upd = sum_base + prod[15:0];

    always_comb
    begin
        state_next      = state_reg;
        prev_next       = prev_reg;
        sum_next        = sum_reg;
        fill_next       = fill_reg;
        n_next          = n_reg;
        chk_next        = chk_reg;
        walk_s_next     = walk_s_reg;
        walk_p_next     = walk_p_reg;
        walk_idx_next   = walk_idx_reg;
        emit_idx_next   = emit_idx_reg;
        pend_valid_next = 1'b0;
        pend_c_next     = pend_c_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_item_next   = out_item_reg;
        q_pop           = 1'b0;
        buf_we          = 1'b0;

        case (state_reg)
            ST_RUN:
            begin
                if (head_valid)
                begin
                    case (head_item.op)
                        OP_SCRAMBLE, OP_UNSCRAMBLE:
                        begin
                            if (out_free)
                            begin
                                q_pop          = 1'b1;
                                out_valid_next = 1'b1;
                                out_item_next.out_byte =
                                    (head_item.op == OP_UNSCRAMBLE) ? uns_r : scr_c;
                                out_item_next.check_sum   = sum_upd;
                                out_item_next.last_result = head_item.eos;
                                prev_next = (head_item.op == OP_UNSCRAMBLE) ?
                                            head_item.data_byte : scr_c;
                                sum_next  = sum_upd;
                                if (head_item.eos)
                                begin
                                    prev_next = '0;
                                    sum_next  = '0;
                                    fill_next = '0;
                                end
                            end
                        end
                        OP_KEY:
                        begin
                            q_pop = 1'b1;
                            n_next   = fill_reg;
                            chk_next = sum_reg;
                            if (room)
                            begin
                                buf_we    = 1'b1;
                                prev_next = scr_c;
                                sum_next  = sum_upd;
                                fill_next = fill_reg + CNT_W'(1);
                                n_next    = fill_reg + CNT_W'(1);
                                chk_next  = sum_upd;
                            end
                            if (head_item.eos)
                            begin
                                walk_s_next   = chk_next;
                                walk_p_next   = '0;
                                walk_idx_next = IDX_W'(n_next - CNT_W'(1));
                                emit_idx_next = '0;
                                prev_next     = '0;
                                sum_next      = '0;
                                fill_next     = '0;
                                state_next    = ST_WALK;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                walk_p_next     = walk_c;
                walk_s_next     = sum_upd;
                pend_valid_next = 1'b1;
                pend_c_next     = walk_c;
                pend_idx_next   = walk_idx_reg;
                if (walk_idx_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    walk_idx_next = walk_idx_reg - IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                // first letter lands this cycle
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.out_byte    = letter_reg[emit_idx_reg];
                    out_item_next.check_sum   = chk_reg;
                    out_item_next.last_result = emit_last;
                    emit_idx_next             = emit_idx_reg + IDX_W'(1);
                    if (emit_last)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            prev_reg       <= '0;
            sum_reg        <= '0;
            fill_reg       <= '0;
            n_reg          <= '0;
            chk_reg        <= '0;
            walk_s_reg     <= '0;
            walk_p_reg     <= '0;
            walk_idx_reg   <= '0;
            emit_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_c_reg     <= '0;
            pend_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_item_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_reg       <= prev_next;
            sum_reg        <= sum_next;
            fill_reg       <= fill_next;
            n_reg          <= n_next;
            chk_reg        <= chk_next;
            walk_s_reg     <= walk_s_next;
            walk_p_reg     <= walk_p_next;
            walk_idx_reg   <= walk_idx_next;
            emit_idx_reg   <= emit_idx_next;
            pend_valid_reg <= pend_valid_next;
            pend_c_reg     <= pend_c_next;
            pend_idx_reg   <= pend_idx_next;
            out_valid_reg  <= out_valid_next;
            out_item_reg   <= out_item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            key_buf_reg[fill_reg[IDX_W-1:0]] <= scr_c;
        end
        if (pend_valid_reg)
        begin
            letter_reg[pend_idx_reg] <= key_letter(pend_c_reg);
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== hdl/bsc_checker.sv =====
// Port-level checks for byte_scrambler_with_checksum, bound to the top level.
// Depends on bsc_pkg.
`default_nettype none

module bsc_port_checks (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [1:0]         cfg_mode,
    input  wire logic               byte_valid,
    input  wire logic               byte_ready,
    input  wire logic               result_valid,
    input  wire logic               result_ready,
    input  wire bsc_pkg::out_item_t result_item
);
    import bsc_pkg::*;

    logic [1:0] mode_reg;
    logic       seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SCRAMBLE;
            seen_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_mode;
            end
            if (byte_valid && byte_ready)
            begin
                seen_reg <= 1'b1;
            end
        end
    end

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped while stalled");

    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_item))
        else $error("result item changed while stalled");

    a_key_letter: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (mode_reg == MODE_KEY) |->
            (result_item.out_byte >= LETTER_A) &&
            (result_item.out_byte < LETTER_A + ALPHA_LEN))
        else $error("key mode result is not a lowercase letter");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> seen_reg)
        else $error("result before any item accepted");

endmodule

bind byte_scrambler_with_checksum bsc_port_checks u_bsc_port_checks (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_mode     (cfg_mode),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
);

`default_nettype wire
